// ===== sv/iban_chk_pkg.sv =====
// Shared constants, types and mod-97 helper functions for the IBAN string checker.
package iban_chk_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [5:0] FULL_LEN    = 6'd36;
    localparam logic [5:0] PREFIX_LEN  = 6'd4;
    localparam logic [6:0] CHECK_OK    = 7'd1;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    // floor(2^16 / 97); the quotient estimate is at most one below the truth
    // for values under 2^14, so one correction step suffices.
    localparam logic [23:0] MOD_RECIP   = 24'd675;
    localparam logic [13:0] MODULUS_W   = 14'd97;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_LONG    = 3'd1,
        ST_BAD_LEN     = 3'd2,
        ST_BAD_COUNTRY = 3'd3,
        ST_WRONG_KIND  = 3'd4,
        ST_BAD_CHAR    = 3'd5,
        ST_BAD_SUM     = 3'd6
    } t_status;

    // Everything the result stage needs from one finished string.
    typedef struct packed {
        logic [6:0] rem;
        logic [6:0] pre_mul;
        logic [6:0] pre_rem;
        logic       len_ok;
        logic       overflow;
        logic       bad_char;
        logic [7:0] pfx0;
        logic [7:0] pfx1;
    } t_snap;

    function automatic logic f_is_digit(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic logic f_is_upper(input logic [7:0] ch);
        return (ch >= CH_A) && (ch <= CH_Z);
    endfunction

    // Remainder modulo 97 of a value below 2^14.
    function automatic logic [6:0] f_mod97(input logic [13:0] x);
        logic [23:0] prod;
        logic [7:0]  q;
        logic [13:0] r;
        prod = {10'd0, x} * MOD_RECIP;
        q    = prod[23:16];
        r    = x - ({6'd0, q} * MODULUS_W);
        if (r >= MODULUS_W) begin
            r = r - MODULUS_W;
        end
        return r[6:0];
    endfunction

    // Folds one character into a remainder; an invalid character leaves it as is.
    function automatic logic [6:0] f_fold(input logic [6:0] rem, input logic [7:0] ch);
        logic [13:0] x;
        logic [7:0]  lv;
        lv = ch - CH_A + LETTER_BASE;
        x  = {7'd0, rem};
        if (f_is_digit(ch)) begin
            x = ({7'd0, rem} * 14'd10) + {10'd0, ch[3:0]};
        end else if (f_is_upper(ch)) begin
            x = ({7'd0, rem} * 14'd100) + {6'd0, lv};
        end
        return f_mod97(x);
    endfunction

    // Weight a character applies to everything folded in before it.
    function automatic logic [6:0] f_scale(input logic [6:0] mul, input logic [7:0] ch);
        logic [13:0] x;
        x = {7'd0, mul};
        if (f_is_digit(ch)) begin
            x = {7'd0, mul} * 14'd10;
        end else if (f_is_upper(ch)) begin
            x = {7'd0, mul} * 14'd100;
        end
        return f_mod97(x);
    endfunction

endpackage

// ===== sv/iban_chk_accum.sv =====
// Per-string accumulator: length, body remainder, prefix fold and error flags.
module iban_chk_accum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_ch,
    input  logic                 i_is_last,
    output iban_chk_pkg::t_snap  o_snap
);

    logic [5:0] r_count, n_count;
    logic [6:0] r_rem, n_rem;
    logic [6:0] r_pre_rem, n_pre_rem;
    logic [6:0] r_pre_mul, n_pre_mul;
    logic [7:0] r_pfx0, n_pfx0;
    logic [7:0] r_pfx1, n_pfx1;
    logic       r_bad, n_bad;
    logic       r_ovf, n_ovf;
    logic       ch_valid;
    iban_chk_pkg::t_snap r_snap, n_snap;

    assign ch_valid = iban_chk_pkg::f_is_digit(i_ch) || iban_chk_pkg::f_is_upper(i_ch);

    // The prefix is folded on its own, together with the factor it multiplies
    // the body remainder by, so the final check is one multiply-add.
    always_comb begin
        n_count   = r_count;
        n_rem     = r_rem;
        n_pre_rem = r_pre_rem;
        n_pre_mul = r_pre_mul;
        n_pfx0    = r_pfx0;
        n_pfx1    = r_pfx1;
        n_bad     = r_bad;
        n_ovf     = r_ovf;
        if (i_step && (i_ch != iban_chk_pkg::CH_SPACE)) begin
            if (r_count >= iban_chk_pkg::FULL_LEN) begin
                n_ovf = 1'b1;
            end else begin
                if (r_count < iban_chk_pkg::PREFIX_LEN) begin
                    if (r_count[1:0] == 2'd0) begin
                        n_pfx0 = i_ch;
                    end
                    if (r_count[1:0] == 2'd1) begin
                        n_pfx1 = i_ch;
                    end
                    n_pre_rem = iban_chk_pkg::f_fold(r_pre_rem, i_ch);
                    n_pre_mul = iban_chk_pkg::f_scale(r_pre_mul, i_ch);
                end else begin
                    n_rem = iban_chk_pkg::f_fold(r_rem, i_ch);
                end
                n_bad   = r_bad | ~ch_valid;
                n_count = r_count + 6'd1;
            end
        end
    end

    always_comb begin
        n_snap.rem      = n_rem;
        n_snap.pre_mul  = n_pre_mul;
        n_snap.pre_rem  = n_pre_rem;
        n_snap.len_ok   = (n_count == iban_chk_pkg::FULL_LEN);
        n_snap.overflow = n_ovf;
        n_snap.bad_char = n_bad;
        n_snap.pfx0     = n_pfx0;
        n_snap.pfx1     = n_pfx1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_is_last)) begin
            r_count   <= '0;
            r_rem     <= '0;
            r_pre_rem <= '0;
            r_pre_mul <= 7'd1;
            r_pfx0    <= '0;
            r_pfx1    <= '0;
            r_bad     <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_rem     <= n_rem;
            r_pre_rem <= n_pre_rem;
            r_pre_mul <= n_pre_mul;
            r_pfx0    <= n_pfx0;
            r_pfx1    <= n_pfx1;
            r_bad     <= n_bad;
            r_ovf     <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_is_last) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap = r_snap;

endmodule

// ===== sv/iban_chk_result.sv =====
// Result stage: folds the prefix into the body remainder and picks the status.
module iban_chk_result (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic                 i_kind,
    input  iban_chk_pkg::t_snap  i_snap,
    output logic [2:0]           o_status,
    output logic                 o_is_account
);

    logic [13:0]           mix;
    logic [6:0]            check;
    logic [7:0]            want;
    iban_chk_pkg::t_status n_status, r_status;
    logic                  n_is_acc, r_is_acc;

    assign mix   = ({7'd0, i_snap.rem} * {7'd0, i_snap.pre_mul}) + {7'd0, i_snap.pre_rem};
    assign check = iban_chk_pkg::f_mod97(mix);
    assign want  = i_kind ? iban_chk_pkg::CH_B : iban_chk_pkg::CH_A;

    always_comb begin
        if (i_snap.overflow) begin
            n_status = iban_chk_pkg::ST_TOO_LONG;
        end else if (!i_snap.len_ok) begin
            n_status = iban_chk_pkg::ST_BAD_LEN;
        end else if (i_snap.pfx1 != iban_chk_pkg::CH_X) begin
            n_status = iban_chk_pkg::ST_BAD_COUNTRY;
        end else if (i_snap.pfx0 != want) begin
            n_status = iban_chk_pkg::ST_WRONG_KIND;
        end else if (i_snap.bad_char) begin
            n_status = iban_chk_pkg::ST_BAD_CHAR;
        end else if (check != iban_chk_pkg::CHECK_OK) begin
            n_status = iban_chk_pkg::ST_BAD_SUM;
        end else begin
            n_status = iban_chk_pkg::ST_OK;
        end
        n_is_acc = (i_snap.pfx0 == iban_chk_pkg::CH_A);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= n_status;
            r_is_acc <= n_is_acc;
        end
    end

    assign o_status     = r_status;
    assign o_is_account = r_is_acc;

endmodule

// ===== sv/iban_string_validator_core.sv =====
// Top level of the IBAN string checker: input register, handshake control and stages.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   i_ch[7:0], i_is_last
//   out       output     o_out_valid / i_out_ready o_status[2:0], o_is_account
//   cfg       input      i_cfg_we                  i_cfg_wdata (expected kind)
//
// One character item is taken every cycle unless the last character is held up. An
// item goes input register -> accumulator (state update and snapshot register) ->
// result register before its status appears. Only the last
// character of a string can hold up the input: it waits while the snapshot
// register is full and the result register is full and not being taken.
// Other characters keep flowing. Reset is synchronous and clears all string
// state and the expected kind.
module iban_string_validator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_is_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic       o_is_account,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    logic       r_kind;
    logic       r_v0, n_v0;
    logic       r_v1, n_v1;
    logic       r_vo, n_vo;
    logic [7:0] r_ch;
    logic       r_last;
    logic       accept;
    logic       step;
    logic       adv1;
    logic       s1_free;
    logic       s2_free;
    iban_chk_pkg::t_snap snap;

    assign s2_free    = !r_vo || i_out_ready;
    assign adv1       = r_v1 && s2_free;
    assign s1_free    = !r_v1 || s2_free;
    assign step       = r_v0 && (!r_last || s1_free);
    assign o_in_ready = !r_v0 || step;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_v0 = accept ? 1'b1 : (step ? 1'b0 : r_v0);
        n_v1 = (step && r_last) ? 1'b1 : (adv1 ? 1'b0 : r_v1);
        n_vo = adv1 ? 1'b1 : ((r_vo && i_out_ready) ? 1'b0 : r_vo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_vo   <= 1'b0;
            r_kind <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
            r_vo <= n_vo;
            if (i_cfg_we) begin
                r_kind <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch   <= i_ch;
            r_last <= i_is_last;
        end
    end

    iban_chk_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_ch      (r_ch),
        .i_is_last (r_last),
        .o_snap    (snap)
    );

    iban_chk_result u_result (
        .i_clk        (i_clk),
        .i_load       (adv1),
        .i_kind       (r_kind),
        .i_snap       (snap),
        .o_status     (o_status),
        .o_is_account (o_is_account)
    );

    assign o_out_valid = r_vo;

endmodule

// ===== tb/iban_string_validator_checker.sv =====
// Checker for the IBAN string checker: predicts each string's status and compares results.
module iban_string_validator_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_is_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_status,
    input  logic       i_is_account,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MOD_97 = 97;

    typedef struct packed {
        iban_chk_pkg::t_status status;
        logic                  is_account;
    } t_verdict;

    t_verdict   verdict_q[$];
    logic       kind_b;
    logic [5:0] seen_len;
    logic [6:0] body_rem;
    logic [7:0] head [4];
    logic       saw_bad;
    logic       saw_extra;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= iban_chk_pkg::CH_ZERO && c <= iban_chk_pkg::CH_NINE) ||
               (c >= iban_chk_pkg::CH_A && c <= iban_chk_pkg::CH_Z);
    endfunction

    // A digit appends one decimal digit, a letter appends the two digits 10..35.
    function automatic logic [6:0] mod97_push(input logic [6:0] r, input logic [7:0] c);
        int unsigned acc;
        acc = 32'(r);
        if (c >= iban_chk_pkg::CH_ZERO && c <= iban_chk_pkg::CH_NINE) begin
            acc = (acc * 10 + 32'(c - iban_chk_pkg::CH_ZERO)) % MOD_97;
        end else if (c >= iban_chk_pkg::CH_A && c <= iban_chk_pkg::CH_Z) begin
            acc = (acc * 100 + 32'(c - iban_chk_pkg::CH_A) + 10) % MOD_97;
        end
        return acc[6:0];
    endfunction

    task clear_line();
        seen_len  = '0;
        body_rem  = '0;
        saw_bad   = 1'b0;
        saw_extra = 1'b0;
        foreach (head[i]) begin
            head[i] = '0;
        end
    endtask

    task note_failure(input string msg);
        $display("t=%0t mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task take_char(input logic [7:0] c, input logic last);
        logic [6:0]            rem;
        logic [7:0]            want_first;
        iban_chk_pkg::t_status st;
        if (c != iban_chk_pkg::CH_SPACE) begin
            if (seen_len >= iban_chk_pkg::FULL_LEN) begin
                saw_extra = 1'b1;
            end else begin
                if (seen_len < iban_chk_pkg::PREFIX_LEN) begin
                    head[seen_len[1:0]] = c;
                end else if (!is_alnum(c)) begin
                    saw_bad = 1'b1;
                end else begin
                    body_rem = mod97_push(body_rem, c);
                end
                seen_len++;
            end
        end
        if (last) begin
            // The prefix is rotated to the end before the remainder is taken.
            rem = body_rem;
            for (int i = 0; i < 4; i++) begin
                if (!is_alnum(head[i])) begin
                    saw_bad = 1'b1;
                end else begin
                    rem = mod97_push(rem, head[i]);
                end
            end
            want_first = kind_b ? iban_chk_pkg::CH_B : iban_chk_pkg::CH_A;
            if (saw_extra) begin
                st = iban_chk_pkg::ST_TOO_LONG;
            end else if (seen_len != iban_chk_pkg::FULL_LEN) begin
                st = iban_chk_pkg::ST_BAD_LEN;
            end else if (head[1] != iban_chk_pkg::CH_X) begin
                st = iban_chk_pkg::ST_BAD_COUNTRY;
            end else if (head[0] != want_first) begin
                st = iban_chk_pkg::ST_WRONG_KIND;
            end else if (saw_bad) begin
                st = iban_chk_pkg::ST_BAD_CHAR;
            end else if (rem != iban_chk_pkg::CHECK_OK) begin
                st = iban_chk_pkg::ST_BAD_SUM;
            end else begin
                st = iban_chk_pkg::ST_OK;
            end
            verdict_q.push_back('{status: st, is_account: (head[0] == iban_chk_pkg::CH_A)});
            clear_line();
        end
    endtask

    // Results are checked before the same edge's input item is taken; a result can
    // never belong to the item accepted at the same edge.
    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (!i_rst_n) begin
            kind_b = 1'b0;
            clear_line();
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                kind_b = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    note_failure($sformatf("result status %0d with nothing expected", i_status));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_status !== want.status) begin
                        note_failure($sformatf("status %0d, expected %0d (%s)",
                                               i_status, want.status, want.status.name()));
                    end
                    if (i_is_account !== want.is_account) begin
                        note_failure($sformatf("is_account %b, expected %b",
                                               i_is_account, want.is_account));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                take_char(i_ch, i_is_last);
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the IBAN string checker: clock, reset, string stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 6;
    localparam int TOTAL_ITEMS   = 1300;
    localparam int RANDOM_PHASES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LINE_LEN      = 36;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] ch        = '0;
    logic       is_last   = 1'b0;
    logic       out_ready = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [2:0] status;
    logic       is_account;

    int   fail_count;
    int   pending;
    int   cycles     = 0;
    int   items_sent = 0;
    bit   idle_on    = 1'b1;
    int   hold_asks  = 0;
    logic kind_now   = 1'b0;

    logic [7:0] line_q[$];

    iban_string_validator_core u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_ch         (ch),
        .i_is_last    (is_last),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_is_account (is_account),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata)
    );

    iban_string_validator_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_ch         (ch),
        .i_is_last    (is_last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_status     (status),
        .i_is_account (is_account),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= iban_chk_pkg::CH_ZERO && c <= iban_chk_pkg::CH_NINE) ||
               (c >= iban_chk_pkg::CH_A && c <= iban_chk_pkg::CH_Z);
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(1)) begin
            return iban_chk_pkg::CH_ZERO + 8'($urandom_range(9));
        end
        return iban_chk_pkg::CH_A + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_junk();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (is_alnum(c) || c == iban_chk_pkg::CH_SPACE);
        return c;
    endfunction

    // Remainder update used only to pick the two check digits of a generated string.
    function automatic logic [6:0] mod97_push(input logic [6:0] r, input logic [7:0] c);
        int unsigned acc;
        acc = 32'(r);
        if (c >= iban_chk_pkg::CH_ZERO && c <= iban_chk_pkg::CH_NINE) begin
            acc = (acc * 10 + 32'(c - iban_chk_pkg::CH_ZERO)) % 97;
        end else if (c >= iban_chk_pkg::CH_A && c <= iban_chk_pkg::CH_Z) begin
            acc = (acc * 100 + 32'(c - iban_chk_pkg::CH_A) + 10) % 97;
        end
        return acc[6:0];
    endfunction

    // Builds a full-length string with the given first two characters and check
    // digits chosen so that the rotated string leaves remainder one.
    task build_line(input logic [7:0] first, input logic [7:0] second);
        logic [6:0] r;
        int         d;
        line_q.delete();
        r = '0;
        repeat (LINE_LEN - 4) line_q.push_back(rand_alnum());
        foreach (line_q[i]) begin
            r = mod97_push(r, line_q[i]);
        end
        r = mod97_push(r, first);
        r = mod97_push(r, second);
        d = (98 - (int'(r) * 100) % 97) % 97;
        if (d <= 2 && $urandom_range(1)) begin
            d += 97;
        end
        line_q.push_front(iban_chk_pkg::CH_ZERO + 8'(d % 10));
        line_q.push_front(iban_chk_pkg::CH_ZERO + 8'(d / 10));
        line_q.push_front(second);
        line_q.push_front(first);
    endtask

    task corrupt_sum();
        int         pos;
        logic [7:0] old;
        pos = $urandom_range(4, LINE_LEN - 1);
        old = line_q[pos];
        do begin
            line_q[pos] = rand_alnum();
        end while (line_q[pos] == old);
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task send_item(input logic [7:0] c, input logic last);
        if (idle_on && $urandom_range(99) < 25) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid = 1'b1;
        ch       = c;
        is_last  = last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task send_line(input bit spaced, input bit trail);
        int n;
        n = line_q.size();
        if (n == 0) begin
            send_item(iban_chk_pkg::CH_SPACE, 1'b1);
        end else begin
            for (int i = 0; i < n; i++) begin
                if (spaced && $urandom_range(99) < 8) begin
                    send_item(iban_chk_pkg::CH_SPACE, 1'b0);
                end
                send_item(line_q[i], (i == n - 1) && !trail);
            end
            if (trail) begin
                send_item(iban_chk_pkg::CH_SPACE, 1'b1);
            end
        end
    endtask

    task drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task set_kind(input logic v);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        kind_now  = v;
    endtask

    task random_line();
        int         pick;
        int         n;
        logic [7:0] want;
        logic [7:0] first;
        logic [7:0] second;
        pick   = $urandom_range(99);
        want   = kind_now ? iban_chk_pkg::CH_B : iban_chk_pkg::CH_A;
        first  = want;
        second = iban_chk_pkg::CH_X;
        if (pick >= 66 && pick < 71) begin
            if ($urandom_range(1)) begin
                first = kind_now ? iban_chk_pkg::CH_A : iban_chk_pkg::CH_B;
            end else begin
                do begin
                    first = rand_alnum();
                end while (first == want);
            end
        end else if (pick >= 71 && pick < 76) begin
            do begin
                second = rand_alnum();
            end while (second == iban_chk_pkg::CH_X);
        end
        build_line(first, second);
        if (pick >= 60 && pick < 66) begin
            corrupt_sum();
        end else if (pick >= 76 && pick < 82) begin
            line_q[$urandom_range(0, LINE_LEN - 1)] = rand_junk();
        end else if (pick >= 82 && pick < 87) begin
            n = $urandom_range(0, LINE_LEN - 1);
            while (line_q.size() > n) line_q.pop_back();
        end else if (pick >= 87 && pick < 92) begin
            repeat ($urandom_range(1, 6)) line_q.push_back(rand_alnum());
        end else if (pick >= 92) begin
            line_q.delete();
            repeat ($urandom_range(1, 45)) line_q.push_back(8'($urandom_range(255)));
        end
        send_line($urandom_range(99) < 30, $urandom_range(99) < 10);
    endtask

    // Output side: random back-pressure, plus one long hold-off on request.
    initial begin : sink
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(negedge clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = !idle_on || ($urandom_range(99) >= 25);
        end
    end

    initial begin : stimulus
        int goal;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed strings with the reset kind (account prefix expected).
        build_line(iban_chk_pkg::CH_A, iban_chk_pkg::CH_X);
        send_line(1'b0, 1'b0);
        build_line(iban_chk_pkg::CH_A, iban_chk_pkg::CH_X);
        send_line(1'b1, 1'b1);
        build_line(iban_chk_pkg::CH_A, iban_chk_pkg::CH_X);
        corrupt_sum();
        send_line(1'b0, 1'b0);
        build_line(iban_chk_pkg::CH_A, iban_chk_pkg::CH_X);
        line_q[10] = 8'h00;
        send_line(1'b0, 1'b0);
        build_line(iban_chk_pkg::CH_A, iban_chk_pkg::CH_X);
        line_q[2] = 8'hFF;
        send_line(1'b0, 1'b0);
        build_line(iban_chk_pkg::CH_B, iban_chk_pkg::CH_X);
        send_line(1'b0, 1'b0);
        build_line(iban_chk_pkg::CH_A, iban_chk_pkg::CH_Z);
        send_line(1'b0, 1'b0);
        line_q = '{iban_chk_pkg::CH_A};
        send_line(1'b0, 1'b0);
        line_q.delete();
        send_line(1'b0, 1'b0);
        build_line(iban_chk_pkg::CH_A, iban_chk_pkg::CH_X);
        repeat (3) line_q.push_back(iban_chk_pkg::CH_NINE);
        send_line(1'b0, 1'b0);

        // Token prefix expected.
        set_kind(1'b1);
        build_line(iban_chk_pkg::CH_B, iban_chk_pkg::CH_X);
        send_line(1'b0, 1'b0);
        build_line(iban_chk_pkg::CH_A, iban_chk_pkg::CH_X);
        send_line(1'b0, 1'b0);

        // Each phase tops the running item count up to its share of the total.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_kind((p == 2 || p == 4) ? 1'b0 : 1'b1);
            idle_on = (p != 3);
            if (p == 1) begin
                // Short strings pile up results while the output is held off.
                hold_asks++;
                repeat (10) begin
                    build_line(kind_now ? iban_chk_pkg::CH_B : iban_chk_pkg::CH_A,
                               iban_chk_pkg::CH_X);
                    while (line_q.size() > 3) line_q.pop_back();
                    send_line(1'b0, 1'b0);
                end
            end
            goal = (p + 1) * TOTAL_ITEMS / RANDOM_PHASES;
            while (items_sent < goal) random_line();
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== iban_string_validator_core.f =====
sv/iban_chk_pkg.sv
sv/iban_chk_accum.sv
sv/iban_chk_result.sv
sv/iban_string_validator_core.sv
tb/iban_string_validator_checker.sv
tb/testbench.sv
